/* design/murmur64a_stream_hash_top_assert.svh */
// ----------------------------------------------------------------------------
// murmur64a_stream_hash_top_assert.svh
// Assertion macros shared by the hash block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef MURMUR64A_STREAM_HASH_TOP_ASSERT_SVH
`define MURMUR64A_STREAM_HASH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define MMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition must never be true out of reset
`define MMH_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MMH_ASSERT(lbl, prop, msg)
`define MMH_NEVER(lbl, cond, msg)
`endif
`endif

/* design/mmh64_pkg.sv */
// ----------------------------------------------------------------------------
// mmh64_pkg
// Constants and command types for the 64-bit murmur stream hasher.
// ----------------------------------------------------------------------------
package mmh64_pkg;

  localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] MIX_M      = 64'hc6a4a7935bd1e995;
  localparam logic [63:0] SEED_RESET = 64'h00000000e17a1465;
  localparam int unsigned FMIX_S     = 33;
  localparam int unsigned MIX_R      = 47;

  // one classified item, front to back
  typedef struct packed {
    logic        is_fixed;  // fixed-value finalizer, else string chunk
    logic        first;     // start a new string
    logic        last;      // finalize and emit
    logic        full;      // eight bytes (count saturated)
    logic        empty;     // zero bytes
    logic [63:0] word;      // value, or chunk with unused bytes cleared
    logic [63:0] total;
    logic [63:0] prior;
  } cmd_t;

  typedef struct packed {
    logic busy;          // back end working on a command
    logic emit_pending;  // result waiting for the output register
  } back_stat_t;

endpackage

/* design/mmh64_fifo.sv */
// ----------------------------------------------------------------------------
// mmh64_fifo
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module mmh64_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mmh64_pkg::cmd_t  data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output mmh64_pkg::cmd_t  data_o
);
  import mmh64_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/mmh64_mul.sv */
// ----------------------------------------------------------------------------
// mmh64_mul
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
// ----------------------------------------------------------------------------
module mmh64_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] prod_o,
  output logic        done_o
);
  import mmh64_pkg::*;

  logic [63:0] ll_d, ll_q;
  logic [31:0] c1_d, c1_q, c2_d, c2_q;
  logic [63:0] prod_q;
  logic        v1_q, done_q;

  // only the low 32 bits of the cross products reach the low word
  assign ll_d = a_i[31:0] * b_i[31:0];
  assign c1_d = a_i[63:32] * b_i[31:0];
  assign c2_d = a_i[31:0] * b_i[63:32];

  always_ff @(posedge clk_i) begin
    ll_q   <= ll_d;
    c1_q   <= c1_d;
    c2_q   <= c2_d;
    prod_q <= ll_q + {c1_q + c2_q, 32'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      done_q <= v1_q;
    end
  end

  assign prod_o = prod_q;
  assign done_o = done_q;

endmodule

/* design/mmh64_front.sv */
// ----------------------------------------------------------------------------
// mmh64_front
// Accepts items, tracks the open string and classifies each item.
// ----------------------------------------------------------------------------
module mmh64_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             action_i,
  input  logic [63:0]      value_word_i,
  input  logic [3:0]       chunk_bytes_i,
  input  logic             first_chunk_i,
  input  logic             last_chunk_i,
  input  logic [63:0]      total_length_i,
  input  logic [63:0]      prior_hash_i,
  input  logic             full_i,
  output logic             push_o,
  output mmh64_pkg::cmd_t  cmd_o
);
  import mmh64_pkg::*;

  logic        in_string_d, in_string_q;
  logic        accept, drop, full_chunk;
  logic [63:0] tail_mask;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !in_stall_o;
  // a continuation chunk with no open string is swallowed here
  assign drop       = action_i && !first_chunk_i && !in_string_q;
  assign push_o     = accept && !drop;

  assign full_chunk = chunk_bytes_i[3];
  assign tail_mask  = (64'd1 << {chunk_bytes_i[2:0], 3'b000}) - 64'd1;

  always_comb begin
    cmd_o.is_fixed = !action_i;
    cmd_o.first    = first_chunk_i;
    cmd_o.last     = last_chunk_i;
    cmd_o.full     = full_chunk;
    cmd_o.empty    = (chunk_bytes_i == 4'd0);
    cmd_o.word     = (!action_i || full_chunk) ? value_word_i : (value_word_i & tail_mask);
    cmd_o.total    = total_length_i;
    cmd_o.prior    = prior_hash_i;
  end

  always_comb begin
    in_string_d = in_string_q;
    if (push_o && action_i) begin
      in_string_d = !last_chunk_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q <= 1'b0;
    end else begin
      in_string_q <= in_string_d;
    end
  end

endmodule

/* design/mmh64_back.sv */
// ----------------------------------------------------------------------------
// mmh64_back
// Sequencer running the hash steps on a shared two-stage multiplier.
// ----------------------------------------------------------------------------
module mmh64_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  mmh64_pkg::cmd_t        cmd_i,
  output logic                   cmd_pop_o,
  input  logic [63:0]            seed_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [63:0]            hash_out_o,
  output mmh64_pkg::back_stat_t  stat_o
);
  import mmh64_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F1,
    ST_F2,
    ST_SEED,
    ST_BODY,
    ST_K1,
    ST_K2,
    ST_HMUL,
    ST_FIN,
    ST_FINAL,
    ST_EMIT
  } state_e;

  state_e      state_d, state_q;
  cmd_t        cmd_d, cmd_q;
  logic [63:0] h_d, h_q;
  logic [63:0] res_d, res_q;
  logic [63:0] out_hash_d, out_hash_q;
  logic        out_valid_d, out_valid_q;

  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_b, prod;

  mmh64_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    h_d         = h_q;
    res_d       = res_q;
    out_hash_d  = out_hash_q;
    out_valid_d = out_valid_q;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = MIX_M;
    cmd_pop_o   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          if (cmd_i.is_fixed) begin
            mul_start = 1'b1;
            mul_a     = cmd_i.word ^ (cmd_i.word >> FMIX_S);
            mul_b     = FMIX_C1;
            state_d   = ST_F1;
          end else if (cmd_i.first) begin
            mul_start = 1'b1;
            mul_a     = cmd_i.total;
            state_d   = ST_SEED;
          end else begin
            state_d = ST_BODY;
          end
        end
      end
      ST_F1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = prod ^ (prod >> FMIX_S);
          mul_b     = FMIX_C2;
          state_d   = ST_F2;
        end
      end
      ST_F2: begin
        if (mul_done) begin
          res_d   = cmd_q.prior ^ prod ^ (prod >> FMIX_S);
          state_d = ST_EMIT;
        end
      end
      ST_SEED: begin
        if (mul_done) begin
          h_d     = seed_i ^ prod;
          state_d = ST_BODY;
        end
      end
      ST_BODY: begin
        if (cmd_q.full) begin
          mul_start = 1'b1;
          mul_a     = cmd_q.word;
          state_d   = ST_K1;
        end else if (!cmd_q.empty) begin
          // tail bytes folded straight into the running hash
          mul_start = 1'b1;
          mul_a     = h_q ^ cmd_q.word;
          state_d   = ST_HMUL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_K1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = prod ^ (prod >> MIX_R);
          state_d   = ST_K2;
        end
      end
      ST_K2: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = h_q ^ prod;
          state_d   = ST_HMUL;
        end
      end
      ST_HMUL: begin
        if (mul_done) begin
          h_d     = prod;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (cmd_q.last) begin
          mul_start = 1'b1;
          mul_a     = h_q ^ (h_q >> MIX_R);
          state_d   = ST_FINAL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (mul_done) begin
          res_d   = cmd_q.prior ^ prod ^ (prod >> MIX_R);
          h_d     = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          out_hash_d  = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      h_q         <= '0;
      res_q       <= '0;
      out_hash_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      h_q         <= h_d;
      res_q       <= res_d;
      out_hash_q  <= out_hash_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign hash_out_o          = out_hash_q;
  assign stat_o.busy         = (state_q != ST_IDLE);
  assign stat_o.emit_pending = (state_q == ST_EMIT);

endmodule

/* design/murmur64a_stream_hash_top.sv */
// ----------------------------------------------------------------------------
// murmur64a_stream_hash_top
// Two-mode 64-bit key hasher: murmur3 finalizer or MurmurHash64A on chunks.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one beat per fixed value or
// per 64-bit string chunk; output channel (out_valid_o / out_stall_i) carries
// one hash per fixed value and per last chunk. Continuation chunks with no
// open string are dropped without a result. string_seed_we_i loads the seed
// used at the first chunk of each string; write it only while idle.
// A front end classifies beats into a command queue; the back end runs each
// command on one shared 64x64 multiplier whose products chain
// through the running hash. Multiplies per beat in the back end:
//   fixed value: two, full chunk: three, tail chunk: one, empty chunk:
//   none, plus one for a first chunk (length scaling) and one for a
//   last chunk (finalize).
// Each result is registered at the output. The queue keeps taking beats,
// until it is full, while the back end works or the output is stalled; a
// stalled result holds in the output register and the back end waits
// behind it. Reset clears the queue, the open string and the output valid;
// the seed returns to its default.
// ----------------------------------------------------------------------------
module murmur64a_stream_hash_top #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        string_seed_we_i,
  input  logic [63:0] string_seed_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [63:0] value_word_i,
  input  logic [3:0]  chunk_bytes_i,
  input  logic        first_chunk_i,
  input  logic        last_chunk_i,
  input  logic [63:0] total_length_i,
  input  logic [63:0] prior_hash_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_out_o
);
  import mmh64_pkg::*;

  logic [63:0] seed_q;
  logic        fifo_push, fifo_full, fifo_pop, fifo_valid;
  cmd_t        front_cmd, fifo_cmd;
  back_stat_t  back_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (string_seed_we_i) begin
      seed_q <= string_seed_i;
    end
  end

  mmh64_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .value_word_i   (value_word_i),
    .chunk_bytes_i  (chunk_bytes_i),
    .first_chunk_i  (first_chunk_i),
    .last_chunk_i   (last_chunk_i),
    .total_length_i (total_length_i),
    .prior_hash_i   (prior_hash_i),
    .full_i         (fifo_full),
    .push_o         (fifo_push),
    .cmd_o          (front_cmd)
  );

  mmh64_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_cmd)
  );

  mmh64_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (fifo_cmd),
    .cmd_pop_o   (fifo_pop),
    .seed_i      (seed_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hash_out_o  (hash_out_o),
    .stat_o      (back_stat)
  );

`include "murmur64a_stream_hash_top_assert.svh"

  `MMH_NEVER(a_no_push_full, fifo_push && fifo_full, "command pushed into full queue")
  `MMH_NEVER(a_no_pop_empty, fifo_pop && !fifo_valid, "command popped from empty queue")
  `MMH_ASSERT(a_pop_idle, fifo_pop |-> !back_stat.busy, "command popped while back end busy")
  `MMH_ASSERT(a_emit_waits, back_stat.emit_pending && out_valid_o && out_stall_i |=> back_stat.emit_pending, "result lost while output stalled")

endmodule
